### sv/gdr_pkg.sv
package gdr_pkg;

  // Input item kinds.
  localparam logic KIND_TILE = 1'b0;
  localparam logic KIND_CAST = 1'b1;

  // Tile code that marks a wall.
  localparam logic [7:0] WALL_CODE = 8'd1;

  // Fixed-point constants.
  localparam int unsigned RECIP_W = 31;           // width of 2^30 / |d|
  localparam int unsigned FRAC_W  = 17;           // width of a Q.16 fraction up to 1.0
  localparam logic [16:0] FRAC_ONE = 17'd65536;
  localparam logic [21:0] DIST_MAX = 22'd4194303;

  // Register indexes of the configuration port.
  localparam logic CFG_PLAYER_X = 1'b0;
  localparam logic CFG_PLAYER_Y = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DX_GO,
    ST_DX_RUN,
    ST_DY_GO,
    ST_DY_RUN,
    ST_SX_GO,
    ST_SX_RUN,
    ST_SY_GO,
    ST_SY_RUN,
    ST_WALK,
    ST_STEP,
    ST_TEST,
    ST_HX_GO,
    ST_HX_RUN,
    ST_HY_GO,
    ST_HY_RUN,
    ST_EMIT
  } state_e;

  // Operand selection of the shared multiplier.
  typedef enum logic [1:0] {
    MUL_SIDE_X,
    MUL_SIDE_Y,
    MUL_HIT_X,
    MUL_HIT_Y
  } mul_sel_e;

  typedef struct packed {
    logic     clr;
    logic     load;
    logic     tile_wr;
    logic     div_go;
    logic     div_sel_y;
    logic     mul_go;
    mul_sel_e mul_sel;
    logic     step;
    logic     test;
  } gdr_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic mul_done;
    logic walk_ok;
    logic stop;
  } gdr_status_t;

  // Magnitude of a signed 16-bit direction component.
  function automatic logic [15:0] abs16(input logic signed [15:0] d);
    logic signed [16:0] e;
    logic [16:0] m;
    e = 17'(d);
    m = (e < 0) ? 17'(-e) : 17'(e);
    return m[15:0];
  endfunction

endpackage

### sv/gdr_div.sv
module gdr_div
  import gdr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                go_i,
  input  logic [15:0]         divisor_i,
  output logic                done_o,
  output logic [RECIP_W-1:0]  quot_o
);

  logic [16:0]        rem_q, rem_d;
  logic [RECIP_W-1:0] quot_q, quot_d;
  logic [15:0]        dvs_q;
  logic [4:0]         cnt_q, cnt_d;
  logic               run_q, run_d;
  logic               done_q, done_d;
  logic [16:0]        rem_sh;
  logic               fits;

  // Restoring division of 2^30 by the divisor, one quotient bit a cycle.
  // Only the leading dividend bit is one.
  always_comb begin
    rem_sh = {rem_q[15:0], (cnt_q == 5'(RECIP_W))};
    fits   = rem_sh >= {1'b0, dvs_q};
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (go_i) begin
      rem_d  = '0;
      quot_d = '0;
      cnt_d  = 5'(RECIP_W);
      run_d  = 1'b1;
    end else if (run_q) begin
      rem_d  = fits ? rem_sh - {1'b0, dvs_q} : rem_sh;
      quot_d = {quot_q[RECIP_W-2:0], fits};
      cnt_d  = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (go_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### sv/gdr_mul.sv
module gdr_mul
  import gdr_pkg::*;
#(
  parameter int unsigned BW = 37
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  go_i,
  input  logic [FRAC_W-1:0]     a_i,
  input  logic [BW-1:0]         b_i,
  output logic                  done_o,
  output logic [BW+FRAC_W-1:0]  prod_o
);

  localparam int unsigned PW = BW + FRAC_W;

  logic [FRAC_W-1:0] a_q;
  logic [PW-1:0]     b_q;
  logic [PW-1:0]     acc_q;
  logic [4:0]        cnt_q;
  logic              run_q;
  logic              done_q;

  // Shift-and-add over the bits of the narrow operand, LSB first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        cnt_q <= 5'(FRAC_W);
        run_q <= 1'b1;
      end else if (run_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      a_q   <= a_i;
      b_q   <= PW'(b_i);
      acc_q <= '0;
    end else if (run_q) begin
      if (a_q[0]) begin
        acc_q <= acc_q + b_q;
      end
      a_q <= a_q >> 1;
      b_q <= b_q << 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

### sv/gdr_ctrl.sv
module gdr_ctrl
  import gdr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        kind_i,
  output logic        busy,
  output logic        result_valid_o,
  input  gdr_status_t status_i,
  output gdr_cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign accept = start && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (status_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:   if (accept && (kind_i == KIND_CAST)) state_d = ST_DX_GO;
      ST_DX_GO:  state_d = ST_DX_RUN;
      ST_DX_RUN: if (status_i.div_done) state_d = ST_DY_GO;
      ST_DY_GO:  state_d = ST_DY_RUN;
      ST_DY_RUN: if (status_i.div_done) state_d = ST_SX_GO;
      ST_SX_GO:  state_d = ST_SX_RUN;
      ST_SX_RUN: if (status_i.mul_done) state_d = ST_SY_GO;
      ST_SY_GO:  state_d = ST_SY_RUN;
      ST_SY_RUN: if (status_i.mul_done) state_d = ST_WALK;
      ST_WALK:   state_d = status_i.walk_ok ? ST_STEP : ST_HX_GO;
      ST_STEP:   state_d = ST_TEST;
      ST_TEST:   state_d = status_i.stop ? ST_HX_GO : ST_STEP;
      ST_HX_GO:  state_d = ST_HX_RUN;
      ST_HX_RUN: if (status_i.mul_done) state_d = ST_HY_GO;
      ST_HY_GO:  state_d = ST_HY_RUN;
      ST_HY_RUN: if (status_i.mul_done) state_d = ST_EMIT;
      ST_EMIT:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o           = '0;
    cmd_o.mul_sel   = MUL_SIDE_X;
    busy            = (state_q != ST_IDLE);
    result_valid_o  = 1'b0;
    case (state_q)
      ST_CLEAR: cmd_o.clr = 1'b1;
      ST_IDLE: begin
        cmd_o.tile_wr = accept && (kind_i == KIND_TILE);
        cmd_o.load    = accept && (kind_i == KIND_CAST);
      end
      ST_DX_GO:  cmd_o.div_go = 1'b1;
      ST_DX_RUN: cmd_o.div_sel_y = 1'b0;
      ST_DY_GO: begin
        cmd_o.div_go    = 1'b1;
        cmd_o.div_sel_y = 1'b1;
      end
      ST_DY_RUN: cmd_o.div_sel_y = 1'b1;
      ST_SX_GO: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = MUL_SIDE_X;
      end
      ST_SX_RUN: cmd_o.mul_sel = MUL_SIDE_X;
      ST_SY_GO: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = MUL_SIDE_Y;
      end
      ST_SY_RUN: cmd_o.mul_sel = MUL_SIDE_Y;
      ST_STEP:   cmd_o.step = 1'b1;
      ST_TEST:   cmd_o.test = 1'b1;
      ST_HX_GO: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = MUL_HIT_X;
      end
      ST_HX_RUN: cmd_o.mul_sel = MUL_HIT_X;
      ST_HY_GO: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = MUL_HIT_Y;
      end
      ST_HY_RUN: cmd_o.mul_sel = MUL_HIT_Y;
      ST_EMIT:   result_valid_o = 1'b1;
      default:   cmd_o = '0;
    endcase
  end

endmodule

### sv/gdr_datapath.sv
module gdr_datapath
  import gdr_pkg::*;
#(
  parameter int unsigned MAP_DIM = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gdr_cmd_t           cmd_i,
  output gdr_status_t        status_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [20:0]        cfg_data_i,
  input  logic [4:0]         tile_row_i,
  input  logic [4:0]         tile_col_i,
  input  logic [7:0]         tile_value_i,
  input  logic signed [15:0] ray_dir_x_i,
  input  logic signed [15:0] ray_dir_y_i,
  output logic [21:0]        ray_distance_o,
  output logic [21:0]        hit_x_o,
  output logic [21:0]        hit_y_o,
  output logic signed [6:0]  cell_x_o,
  output logic signed [6:0]  cell_y_o,
  output logic               side_vertical_o,
  output logic               wall_found_o
);

  localparam int unsigned CW_MIN = $clog2(MAP_DIM + 1) + 1;
  localparam int unsigned CW     = (CW_MIN > 7) ? CW_MIN : 7;
  localparam int unsigned DEPTH  = MAP_DIM * MAP_DIM;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned SIDE_W = RECIP_W + $clog2(MAP_DIM + 3);
  localparam int unsigned PW     = SIDE_W + FRAC_W;
  localparam int unsigned OW     = PW - 14;
  localparam int unsigned HW     = OW + 2;
  localparam int unsigned LW     = 2 * CW;
  localparam logic [CW-1:0] DIM_C = CW'(MAP_DIM);
  localparam logic signed [HW-1:0] TOP_C = HW'(MAP_DIM * 65536);

  // Configuration registers.
  logic [20:0] player_x_q, player_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      player_x_q <= 21'd65536;
      player_y_q <= 21'd65536;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PLAYER_X: player_x_q <= cfg_data_i;
        CFG_PLAYER_Y: player_y_q <= cfg_data_i;
        default:      player_x_q <= player_x_q;
      endcase
    end
  end

  // Ray state.
  logic signed [15:0]  dir_x_q, dir_y_q;
  logic [RECIP_W-1:0]  delx_q, dely_q;
  logic [SIDE_W-1:0]   sidex_q, sidey_q, dist_q;
  logic signed [CW-1:0] cx_q, cy_q;
  logic                vert_q, wall_q;
  logic [21:0]         hitx_q, hity_q;

  logic        dx_nz, dy_nz, dx_pos, dy_pos;
  logic [15:0] mag_x, mag_y;
  logic [16:0] frac_x, frac_y;

  assign dx_nz  = (dir_x_q != '0);
  assign dy_nz  = (dir_y_q != '0);
  assign dx_pos = dx_nz && !dir_x_q[15];
  assign dy_pos = dy_nz && !dir_y_q[15];
  assign mag_x  = abs16(dir_x_q);
  assign mag_y  = abs16(dir_y_q);
  assign frac_x = dx_pos ? FRAC_ONE - {1'b0, player_x_q[15:0]} : {1'b0, player_x_q[15:0]};
  assign frac_y = dy_pos ? FRAC_ONE - {1'b0, player_y_q[15:0]} : {1'b0, player_y_q[15:0]};

  // Shared reciprocal divider.
  logic               div_done;
  logic [RECIP_W-1:0] div_quot;

  gdr_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (cmd_i.div_go),
    .divisor_i (cmd_i.div_sel_y ? mag_y : mag_x),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // Shared multiplier for the first boundary distances and the hit offsets.
  logic [FRAC_W-1:0] mul_a;
  logic [SIDE_W-1:0] mul_b;
  logic              mul_done;
  logic [PW-1:0]     mul_prod;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_SIDE_X: begin
        mul_a = frac_x;
        mul_b = SIDE_W'(delx_q);
      end
      MUL_SIDE_Y: begin
        mul_a = frac_y;
        mul_b = SIDE_W'(dely_q);
      end
      MUL_HIT_X: begin
        mul_a = FRAC_W'(mag_x);
        mul_b = dist_q;
      end
      MUL_HIT_Y: begin
        mul_a = FRAC_W'(mag_y);
        mul_b = dist_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  gdr_mul #(.BW(SIDE_W)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.mul_go),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  // Hit point: player plus signed offset, clamped to the map.
  logic [OW-1:0]        off;
  logic signed [HW-1:0] hp, hsum, hclamp;
  logic                 hneg;

  always_comb begin
    off  = mul_prod[PW-1:14];
    hneg = (cmd_i.mul_sel == MUL_HIT_X) ? dir_x_q[15] : dir_y_q[15];
    hp   = (cmd_i.mul_sel == MUL_HIT_X) ? HW'(player_x_q) : HW'(player_y_q);
    hsum = hneg ? hp - HW'(off) : hp + HW'(off);
    if (hsum < 0) begin
      hclamp = '0;
    end else if (hsum > TOP_C) begin
      hclamp = TOP_C;
    end else begin
      hclamp = hsum;
    end
  end

  // Next DDA step: cross the nearer boundary.
  logic                 stepx;
  logic signed [CW-1:0] nx, ny;
  logic                 n_in, c_in;
  logic [LW-1:0]        rd_lin;

  always_comb begin
    stepx = dx_nz && (!dy_nz || (sidex_q < sidey_q));
    nx    = cx_q;
    ny    = cy_q;
    if (stepx) begin
      nx = dx_pos ? cx_q + CW'(1) : cx_q - CW'(1);
    end else begin
      ny = dy_pos ? cy_q + CW'(1) : cy_q - CW'(1);
    end
    n_in   = (nx >= 0) && (ny >= 0) && (nx < $signed(DIM_C)) && (ny < $signed(DIM_C));
    c_in   = (cx_q >= 0) && (cy_q >= 0) && (cx_q < $signed(DIM_C)) &&
             (cy_q < $signed(DIM_C));
    rd_lin = LW'($unsigned(ny)) * LW'(DIM_C) + LW'($unsigned(nx));
  end

  // Wall map memory with a clearing sweep after reset.
  logic          mem [DEPTH];
  logic          rd_q;
  logic [AW-1:0] clr_cnt_q;
  logic          tile_in;
  logic [LW-1:0] wr_lin;

  assign tile_in = (9'(tile_row_i) < 9'(MAP_DIM)) && (9'(tile_col_i) < 9'(MAP_DIM));
  assign wr_lin  = LW'(tile_row_i) * LW'(DIM_C) + LW'(tile_col_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      mem[clr_cnt_q] <= 1'b0;
    end else if (cmd_i.tile_wr && tile_in) begin
      mem[wr_lin[AW-1:0]] <= (tile_value_i == WALL_CODE);
    end
    if (cmd_i.step && n_in) begin
      rd_q <= mem[rd_lin[AW-1:0]];
    end
  end

  // Ray registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dir_x_q <= ray_dir_x_i;
      dir_y_q <= ray_dir_y_i;
      cx_q    <= CW'(player_x_q[20:16]);
      cy_q    <= CW'(player_y_q[20:16]);
      dist_q  <= '0;
      vert_q  <= 1'b0;
      wall_q  <= 1'b0;
    end
    if (div_done) begin
      if (cmd_i.div_sel_y) begin
        dely_q <= div_quot;
      end else begin
        delx_q <= div_quot;
      end
    end
    if (mul_done) begin
      case (cmd_i.mul_sel)
        MUL_SIDE_X: sidex_q <= mul_prod[SIDE_W+15:16];
        MUL_SIDE_Y: sidey_q <= mul_prod[SIDE_W+15:16];
        MUL_HIT_X:  hitx_q  <= hclamp[21:0];
        MUL_HIT_Y:  hity_q  <= hclamp[21:0];
        default:    hitx_q  <= hitx_q;
      endcase
    end
    if (cmd_i.step) begin
      cx_q <= nx;
      cy_q <= ny;
      if (stepx) begin
        dist_q  <= sidex_q;
        sidex_q <= sidex_q + SIDE_W'(delx_q);
        vert_q  <= 1'b1;
      end else begin
        dist_q  <= sidey_q;
        sidey_q <= sidey_q + SIDE_W'(dely_q);
        vert_q  <= 1'b0;
      end
    end
    if (cmd_i.test) begin
      wall_q <= c_in && rd_q;
    end
  end

  // Status to the controller.
  always_comb begin
    status_o.clr_last = (clr_cnt_q == AW'(DEPTH - 1));
    status_o.div_done = div_done;
    status_o.mul_done = mul_done;
    status_o.walk_ok  = (dx_nz || dy_nz) && (9'(player_x_q[20:16]) < 9'(MAP_DIM)) &&
                        (9'(player_y_q[20:16]) < 9'(MAP_DIM));
    status_o.stop     = !c_in || rd_q;
  end

  // Result fields.
  assign ray_distance_o  = (dist_q > SIDE_W'(DIST_MAX)) ? DIST_MAX : dist_q[21:0];
  assign hit_x_o         = hitx_q;
  assign hit_y_o         = hity_q;
  assign cell_x_o        = cx_q[6:0];
  assign cell_y_o        = cy_q[6:0];
  assign side_vertical_o = vert_q;
  assign wall_found_o    = wall_q;

endmodule

### sv/grid_dda_ray_caster.sv
// Grid ray caster over a square wall map.
// Items enter on start/busy: an item transfers at a clock edge with start high
// and busy low. A tile item (kind 0) writes one map cell in that same cycle and
// gives no result; busy stays low, so a new item may follow at once.
// A cast item (kind 1) gives one result, shown on the result ports for a single
// cycle with result_valid_o high; the receiver takes it then and cannot stall.
// A cast runs two reciprocal divisions, two serial multiplications for the
// first boundary distances and a walk decision; then, until the ray leaves
// the map or meets a wall, each grid step (at most 2 * MAP_DIM) takes one
// stepping state and one map-testing state; two serial multiplications for
// the hit point end the cast.
// Casts run one at a time; busy is high until the result cycle has passed.
// Configuration writes transfer on cfg_valid_i and cfg_ready_o (always high);
// the user must make them while the block is idle; the block does not enforce it.
// After reset the map is swept clear one cell a cycle, all MAP_DIM * MAP_DIM cells,
// with busy high; the player position resets to (1.0, 1.0).
module grid_dda_ray_caster
  import gdr_pkg::*;
#(
  parameter int unsigned MAP_DIM = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               kind_i,
  input  logic [4:0]         tile_row_i,
  input  logic [4:0]         tile_col_i,
  input  logic [7:0]         tile_value_i,
  input  logic signed [15:0] ray_dir_x_i,
  input  logic signed [15:0] ray_dir_y_i,
  output logic               result_valid_o,
  output logic [21:0]        ray_distance_o,
  output logic [21:0]        hit_x_o,
  output logic [21:0]        hit_y_o,
  output logic signed [6:0]  cell_x_o,
  output logic signed [6:0]  cell_y_o,
  output logic               side_vertical_o,
  output logic               wall_found_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [20:0]        cfg_data_i
);

  gdr_cmd_t    cmd;
  gdr_status_t status;

  assign cfg_ready_o = 1'b1;

  gdr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .kind_i         (kind_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  gdr_datapath #(.MAP_DIM(MAP_DIM)) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .tile_row_i      (tile_row_i),
    .tile_col_i      (tile_col_i),
    .tile_value_i    (tile_value_i),
    .ray_dir_x_i     (ray_dir_x_i),
    .ray_dir_y_i     (ray_dir_y_i),
    .ray_distance_o  (ray_distance_o),
    .hit_x_o         (hit_x_o),
    .hit_y_o         (hit_y_o),
    .cell_x_o        (cell_x_o),
    .cell_y_o        (cell_y_o),
    .side_vertical_o (side_vertical_o),
    .wall_found_o    (wall_found_o)
  );

endmodule
